[src/btlp_pkg.sv]
// ----------------------------------------------------------------------------
// btlp_pkg: shared types and constants of the tile layout packer
// Configuration and cell record types, register indexes, carrier codes and
// the padded plane geometry.
// ----------------------------------------------------------------------------
package btlp_pkg;

   localparam int unsigned MAX_PADDED_ROWS    = 1024;
   localparam int unsigned MAX_PADDED_COLUMNS = 2048;
   localparam int unsigned CELL_SPAN          = MAX_PADDED_ROWS * MAX_PADDED_COLUMNS;

   localparam int unsigned CELL_INDEX_W = 21;
   localparam int unsigned CARRIER_W    = 32;
   localparam int unsigned ACCUM_W      = 64;

   // register indexes (byte address / 4)
   localparam logic [2:0] CSR_ROW_COUNT    = 3'd0;
   localparam logic [2:0] CSR_COLUMN_COUNT = 3'd1;
   localparam logic [2:0] CSR_ELEMENT_BITS = 3'd2;
   localparam logic [2:0] CSR_CARRIER_CODE = 3'd3;
   localparam logic [2:0] CSR_TILE_COLUMNS = 3'd4;
   localparam logic [2:0] CSR_START_OFFSET = 3'd5;

   // carrier cell sizes
   localparam logic [1:0] CARRIER_BYTE = 2'd0;
   localparam logic [1:0] CARRIER_HALF = 2'd1;
   localparam logic [1:0] CARRIER_WORD = 2'd2;

   typedef struct packed {
      logic [10:0] row_count;
      logic [11:0] column_count;
      logic [6:0]  element_bits;
      logic [1:0]  carrier_code;
      logic [6:0]  tile_columns;
      logic [2:0]  start_offset;
   } btlp_cfg_type;

   typedef struct packed {
      logic [CELL_INDEX_W-1:0] cell_index;
      logic [CARRIER_W-1:0]    carrier_data;
      logic                    last_of_byte;
      logic                    plane_done;
   } btlp_cell_type;

endpackage

[src/btlp_csr.sv]
// ----------------------------------------------------------------------------
// btlp_csr: configuration registers
// APB-style register file, one 32-bit word per register, never adds wait states.
// ----------------------------------------------------------------------------
module btlp_csr
   import btlp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready,
   output btlp_cfg_type cfg
);

   btlp_cfg_type cfg_ff, cfg_in;
   logic [2:0]   reg_index;
   logic         write_en;

   assign reg_index  = csr_paddr[4:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            CSR_ROW_COUNT:    cfg_in.row_count    = csr_pwdata[10:0];
            CSR_COLUMN_COUNT: cfg_in.column_count = csr_pwdata[11:0];
            CSR_ELEMENT_BITS: cfg_in.element_bits = csr_pwdata[6:0];
            CSR_CARRIER_CODE: cfg_in.carrier_code = csr_pwdata[1:0];
            CSR_TILE_COLUMNS: cfg_in.tile_columns = csr_pwdata[6:0];
            CSR_START_OFFSET: cfg_in.start_offset = csr_pwdata[2:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         CSR_ROW_COUNT:    csr_prdata = {21'd0, cfg_ff.row_count};
         CSR_COLUMN_COUNT: csr_prdata = {20'd0, cfg_ff.column_count};
         CSR_ELEMENT_BITS: csr_prdata = {25'd0, cfg_ff.element_bits};
         CSR_CARRIER_CODE: csr_prdata = {30'd0, cfg_ff.carrier_code};
         CSR_TILE_COLUMNS: csr_prdata = {25'd0, cfg_ff.tile_columns};
         CSR_START_OFFSET: csr_prdata = {29'd0, cfg_ff.start_offset};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_count    <= 11'd1;
         cfg_ff.column_count <= 12'd1;
         cfg_ff.element_bits <= 7'd8;
         cfg_ff.carrier_code <= CARRIER_WORD;
         cfg_ff.tile_columns <= 7'd1;
         cfg_ff.start_offset <= 3'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/btlp_tile_index.sv]
// ----------------------------------------------------------------------------
// btlp_tile_index: tile-major cell address
// Maps a row and native column to 32x32 tiles of four 16x16 faces, wrapped
// to the padded plane size.
// ----------------------------------------------------------------------------
module btlp_tile_index
   import btlp_pkg::*;
(
   input  logic [10:0]             row,
   input  logic [12:0]             column,
   input  logic [6:0]              tile_columns,
   output logic [CELL_INDEX_W-1:0] cell_index
);

   logic [12:0] tile_row_base;
   logic [13:0] tile;
   logic [23:0] index_full;

   assign tile_row_base = {7'd0, row[10:5]} * {6'd0, tile_columns};
   assign tile          = {1'b0, tile_row_base} + {6'd0, column[12:5]};
   // face is {row bit 4, column bit 4}; inside a face the order is row-major
   assign index_full    = {tile, row[4], column[4], row[3:0], column[3:0]};
   assign cell_index    = CELL_INDEX_W'({8'd0, index_full} % CELL_SPAN);

endmodule

[src/btlp_bit_gather.sv]
// ----------------------------------------------------------------------------
// btlp_bit_gather: byte register and element extraction
// Holds one byte, pulls its elements out of it while the output stage is ready, walks the
// row/column counters and builds the carrier cell for the output stage.
// ----------------------------------------------------------------------------
module btlp_bit_gather
   import btlp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  btlp_cfg_type  cfg,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_source_byte,
   input  logic          out_ready,
   output logic          cell_valid,
   output btlp_cell_type cell_out
);

   logic               work_valid_ff, work_valid_in;
   logic [7:0]         byte_ff, byte_in;
   logic [2:0]         pos_ff, pos_in;
   logic               part_ff, part_in;
   logic [ACCUM_W-1:0] accum_ff, accum_in;
   logic [6:0]         fill_ff, fill_in;
   logic [10:0]        row_ff, row_in;
   logic [11:0]        col_ff, col_in;
   logic               pending_ff, pending_in;
   logic               finished_ff, finished_in;

   logic [6:0]         width;
   logic               two_parts;
   logic [6:0]         need;
   logic [3:0]         avail;
   logic               complete;
   logic [3:0]         take;
   logic [7:0]         take_mask;
   logic [7:0]         new_bits;
   logic [ACCUM_W-1:0] merged;
   logic [ACCUM_W-1:0] width_mask;
   logic [ACCUM_W-1:0] value;
   logic [3:0]         rem_pos;
   logic [3:0]         rem;
   logic               more;
   logic               col_last;
   logic               row_last;
   logic               last_elem;
   logic               final_part;
   logic [12:0]        native_col;
   logic [ACCUM_W-1:0] part_value;
   logic [CARRIER_W-1:0] carrier_mask;
   logic               step_en;
   logic               byte_done;
   logic               plane_empty;

   assign width = (cfg.element_bits == 7'd0) ? 7'd1 :
                  (cfg.element_bits > 7'd64) ? 7'd64 : cfg.element_bits;
   assign two_parts = width > 7'd32;

   // bits still needed to close the element; a fill already past the width
   // closes it on the next bit
   assign need      = (fill_ff >= width) ? 7'd1 : width - fill_ff;
   assign avail     = 4'd8 - {1'b0, pos_ff};
   assign complete  = need <= {3'd0, avail};
   assign take      = complete ? need[3:0] : avail;
   assign take_mask = 8'((9'd1 << take) - 9'd1);
   assign new_bits  = (byte_ff >> pos_ff) & take_mask;
   assign merged    = accum_ff | ({56'd0, new_bits} << fill_ff);
   assign width_mask = (width == 7'd64) ? '1 : ((64'd1 << width) - 64'd1);
   assign value     = merged & width_mask;

   assign rem_pos   = {1'b0, pos_ff} + need[3:0];
   assign rem       = 4'd8 - rem_pos;
   assign more      = {3'd0, rem} >= width;

   assign col_last  = ({1'b0, col_ff} + 13'd1) >= {1'b0, cfg.column_count};
   assign row_last  = ({1'b0, row_ff} + 12'd1) >= {1'b0, cfg.row_count};
   assign last_elem = col_last && row_last;
   assign final_part = !two_parts || part_ff;
   assign native_col = two_parts ? {col_ff, part_ff} : {1'b0, col_ff};

   assign plane_empty = (cfg.row_count == 11'd0) || (cfg.column_count == 12'd0);

   always_comb begin
      case (cfg.carrier_code)
         CARRIER_BYTE: begin
            part_value   = part_ff ? (value >> 8) : value;
            carrier_mask = 32'h0000_00FF;
         end
         CARRIER_HALF: begin
            part_value   = part_ff ? (value >> 16) : value;
            carrier_mask = 32'h0000_FFFF;
         end
         default: begin
            part_value   = part_ff ? (value >> 32) : value;
            carrier_mask = 32'hFFFF_FFFF;
         end
      endcase
   end

   btlp_tile_index u_tile_index (
      .row          (row_ff),
      .column       (native_col),
      .tile_columns (cfg.tile_columns),
      .cell_index   (cell_out.cell_index)
   );

   assign cell_out.carrier_data = part_value[CARRIER_W-1:0] & carrier_mask;
   assign cell_out.last_of_byte = final_part && (last_elem || !more);
   assign cell_out.plane_done   = final_part && last_elem;

   assign step_en = work_valid_ff && out_ready;

   always_comb begin
      work_valid_in = work_valid_ff;
      byte_in       = byte_ff;
      pos_in        = pos_ff;
      part_in       = part_ff;
      accum_in      = accum_ff;
      fill_in       = fill_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      pending_in    = pending_ff;
      finished_in   = finished_ff;
      cell_valid    = 1'b0;
      byte_done     = 1'b0;

      if (step_en) begin
         if (finished_ff) begin
            // drop items past the end of the plane
            byte_done = 1'b1;
         end else if (!complete) begin
            accum_in  = merged;
            fill_in   = fill_ff + {3'd0, avail};
            byte_done = 1'b1;
         end else begin
            cell_valid = 1'b1;
            if (two_parts && !part_ff) begin
               part_in = 1'b1;
            end else begin
               part_in  = 1'b0;
               accum_in = '0;
               fill_in  = 7'd0;
               if (col_last) begin
                  col_in = 12'd0;
                  if (row_last) begin
                     row_in      = 11'd0;
                     finished_in = 1'b1;
                  end else begin
                     row_in = row_ff + 11'd1;
                  end
               end else begin
                  col_in = col_ff + 12'd1;
               end
               if (last_elem) begin
                  byte_done = 1'b1;
               end else if (more) begin
                  pos_in = rem_pos[2:0];
               end else begin
                  // too few bits left for another element: absorb them
                  accum_in  = {56'd0, byte_ff >> rem_pos};
                  fill_in   = {3'd0, rem};
                  byte_done = 1'b1;
               end
            end
         end
      end

      if (byte_done) begin
         work_valid_in = 1'b0;
      end

      req_ready = !work_valid_ff || byte_done;

      if (req_valid && req_ready && !plane_empty) begin
         work_valid_in = 1'b1;
         byte_in       = req_source_byte;
         pos_in        = pending_ff ? cfg.start_offset : 3'd0;
         part_in       = 1'b0;
         pending_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         part_ff       <= 1'b0;
         accum_ff      <= '0;
         fill_ff       <= 7'd0;
         row_ff        <= 11'd0;
         col_ff        <= 12'd0;
         pending_ff    <= 1'b1;
         finished_ff   <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         part_ff       <= part_in;
         accum_ff      <= accum_in;
         fill_ff       <= fill_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         pending_ff    <= pending_in;
         finished_ff   <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      pos_ff  <= pos_in;
   end

endmodule

[src/bitstream_to_tile_layout_packer.sv]
// ----------------------------------------------------------------------------
// bitstream_to_tile_layout_packer: packed bitstream to tiled cell stream
// The first cell of an item passes the byte register, then the output register.
// Throughput: an item holds the byte register until its cells have entered the
// single output register that moves one cell per cycle while rsp_ready is high.
// A new item is taken in the cycle that the previous one finishes.
// Reset (synchronous): restores register defaults and clears all plane state.
// ----------------------------------------------------------------------------
module bitstream_to_tile_layout_packer
   import btlp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_source_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [CELL_INDEX_W-1:0] rsp_cell_index,
   output logic [CARRIER_W-1:0]    rsp_carrier_data,
   output logic                    rsp_last_of_byte,
   output logic                    rsp_plane_done,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [4:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   btlp_cfg_type  cfg;
   btlp_cell_type gather_cell;
   logic          cell_valid;
   logic          out_advance;

   logic          rsp_valid_ff, rsp_valid_in;
   btlp_cell_type rsp_cell_ff, rsp_cell_in;

   btlp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   btlp_bit_gather u_gather (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_source_byte (req_source_byte),
      .out_ready       (out_advance),
      .cell_valid      (cell_valid),
      .cell_out        (gather_cell)
   );

   // output register advances when empty or when its cell is taken
   assign out_advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_cell_in  = rsp_cell_ff;
      if (out_advance) begin
         rsp_valid_in = cell_valid;
         rsp_cell_in  = gather_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cell_ff <= rsp_cell_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_index   = rsp_cell_ff.cell_index;
   assign rsp_carrier_data = rsp_cell_ff.carrier_data;
   assign rsp_last_of_byte = rsp_cell_ff.last_of_byte;
   assign rsp_plane_done   = rsp_cell_ff.plane_done;

endmodule

[sim/bitstream_to_tile_layout_packer_tb.sv]
// ----------------------------------------------------------------------------
// bitstream_to_tile_layout_packer_tb: self-checking bench for the tile packer
// Feeds packed source bytes through a valid/ready driver and predicts every
// carrier cell with a bit-level model of the element gatherer and the tiled
// address map. Layout registers change over APB between drained phases. The
// monitor checks each cell in order. The first phases are directed, the rest
// are random.
// ----------------------------------------------------------------------------
module bitstream_to_tile_layout_packer_tb;
   import btlp_pkg::*;

   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned SETTLE_CYCLES = 12;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [7:0]              req_source_byte = 8'h00;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [CELL_INDEX_W-1:0] rsp_cell_index;
   logic [CARRIER_W-1:0]    rsp_carrier_data;
   logic                    rsp_last_of_byte;
   logic                    rsp_plane_done;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [4:0]              csr_paddr = 5'd0;
   logic [31:0]             csr_pwdata = 32'd0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   bitstream_to_tile_layout_packer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_source_byte  (req_source_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cell_index   (rsp_cell_index),
      .rsp_carrier_data (rsp_carrier_data),
      .rsp_last_of_byte (rsp_last_of_byte),
      .rsp_plane_done   (rsp_plane_done),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // layout shadow and gatherer state
   btlp_cfg_type  layout = '{11'd1, 12'd1, 7'd8, CARRIER_WORD, 7'd1, 3'd0};
   logic [63:0]   acc_bits = 64'd0;
   int unsigned   acc_len = 0;
   int unsigned   cur_row = 0;
   int unsigned   cur_col = 0;
   logic          awaiting_first = 1'b1;
   logic          plane_closed = 1'b0;

   logic [7:0]    src_bytes[$];
   btlp_cell_type cells_due[$];
   logic          req_taken = 1'b0;
   int unsigned   quiet_cycles = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   send_idle_pct = 18;
   int unsigned   rsp_stall_pct = 48;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [CELL_INDEX_W-1:0] cell_addr(input int unsigned r,
                                                         input int unsigned c);
      logic [63:0] tile;
      logic [63:0] face;
      logic [63:0] idx;
      tile = 64'(r / 32) * 64'(layout.tile_columns) + 64'(c / 32);
      face = 64'(((r % 32) / 16) * 2 + (c % 32) / 16);
      idx = tile * 1024 + face * 256 + 64'(r % 16) * 16 + 64'(c % 16);
      idx = idx % 64'(CELL_SPAN);
      return idx[CELL_INDEX_W-1:0];
   endfunction

   // gather the bits of one source byte and queue the cells it completes
   task automatic pack_source_byte(input logic [7:0] src);
      int unsigned   width;
      int unsigned   cbytes;
      int unsigned   parts;
      int unsigned   b;
      int unsigned   p;
      int unsigned   n;
      logic [63:0]   value;
      logic [63:0]   cmask;
      logic          last_elem;
      btlp_cell_type held;
      if (plane_closed || layout.row_count == 0 || layout.column_count == 0) return;
      width = layout.element_bits == 0 ? 1 :
              (layout.element_bits > 64 ? 64 : int'(layout.element_bits));
      case (layout.carrier_code)
         CARRIER_BYTE: cbytes = 1;
         CARRIER_HALF: cbytes = 2;
         default:      cbytes = 4;
      endcase
      cmask = (64'd1 << (cbytes * 8)) - 64'd1;
      parts = width > 32 ? 2 : 1;
      b = 0;
      n = 0;
      held = '0;
      if (awaiting_first) begin
         b = layout.start_offset;
         awaiting_first = 1'b0;
      end
      for (; b < 8 && !plane_closed; b++) begin
         if (acc_len < 64) acc_bits[acc_len] = src[b];
         acc_len++;
         if (acc_len >= width) begin
            value = acc_bits;
            if (width < 64) value &= (64'd1 << width) - 64'd1;
            last_elem = (cur_col + 1 >= layout.column_count) &&
                        (cur_row + 1 >= layout.row_count);
            for (p = 0; p < parts; p++) begin
               if (n > 0) cells_due.push_back(held);
               held.cell_index   = cell_addr(cur_row, cur_col * parts + p);
               held.carrier_data = 32'((value >> (p * cbytes * 8)) & cmask);
               held.last_of_byte = 1'b0;
               held.plane_done   = last_elem && (p + 1 == parts);
               n++;
            end
            acc_bits = 64'd0;
            acc_len = 0;
            if (cur_col + 1 >= layout.column_count) begin
               cur_col = 0;
               if (cur_row + 1 >= layout.row_count) begin
                  cur_row = 0;
                  plane_closed = 1'b1;
               end else begin
                  cur_row++;
               end
            end else begin
               cur_col++;
            end
         end
      end
      if (n > 0) begin
         held.last_of_byte = 1'b1;
         cells_due.push_back(held);
      end
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 100) $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   task automatic check_cell();
      btlp_cell_type want;
      if (cells_due.size() == 0) begin
         report_mismatch($sformatf("unexpected cell at index %0h", rsp_cell_index));
         return;
      end
      want = cells_due.pop_front();
      if (rsp_cell_index !== want.cell_index)
         report_mismatch($sformatf("cell_index %0h, want %0h",
                                   rsp_cell_index, want.cell_index));
      if (rsp_carrier_data !== want.carrier_data)
         report_mismatch($sformatf("carrier_data %0h at %0h, want %0h",
                                   rsp_carrier_data, want.cell_index, want.carrier_data));
      if (rsp_last_of_byte !== want.last_of_byte)
         report_mismatch($sformatf("last_of_byte %b at %0h, want %b",
                                   rsp_last_of_byte, want.cell_index, want.last_of_byte));
      if (rsp_plane_done !== want.plane_done)
         report_mismatch($sformatf("plane_done %b at %0h, want %b",
                                   rsp_plane_done, want.cell_index, want.plane_done));
   endtask

   // source byte driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the item until it is taken
      end else if (src_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
         req_source_byte <= src_bytes.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) pack_source_byte(req_source_byte);
         if (rsp_valid && rsp_ready) check_cell();
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress, %0d cells still due", cells_due.size());
            $display("FAILURE");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic csr_write(input logic [2:0] reg_idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (reg_idx)
         CSR_ROW_COUNT:    layout.row_count    = value[10:0];
         CSR_COLUMN_COUNT: layout.column_count = value[11:0];
         CSR_ELEMENT_BITS: layout.element_bits = value[6:0];
         CSR_CARRIER_CODE: layout.carrier_code = value[1:0];
         CSR_TILE_COLUMNS: layout.tile_columns = value[6:0];
         CSR_START_OFFSET: layout.start_offset = value[2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_layout(input int unsigned rows, input int unsigned cols,
                             input int unsigned bits, input logic [1:0] code,
                             input int unsigned tcols, input int unsigned offset);
      csr_write(CSR_ROW_COUNT, rows);
      csr_write(CSR_COLUMN_COUNT, cols);
      csr_write(CSR_ELEMENT_BITS, bits);
      csr_write(CSR_CARRIER_CODE, code);
      csr_write(CSR_TILE_COLUMNS, tcols);
      csr_write(CSR_START_OFFSET, offset);
   endtask

   task automatic queue_random(input int unsigned count);
      repeat (count) src_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // wait until every item is taken and every cell is out, then let the block settle
   task automatic drain();
      do @(posedge clock);
      while (src_bytes.size() != 0 || req_valid || cells_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned chunk;
      int unsigned rows;
      int unsigned cols;
      int unsigned bits;
      int unsigned tcols;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // empty plane: bytes drop and the start offset stays armed
      csr_write(CSR_ROW_COUNT, 0);
      src_bytes.push_back(8'hFF);
      src_bytes.push_back(8'h00);
      drain();

      // one-bit elements from the last start bit, tile columns zero
      set_layout(2047, 3, 1, CARRIER_BYTE, 0, 7);
      src_bytes.push_back(8'hFF);
      src_bytes.push_back(8'h00);
      src_bytes.push_back(8'hA5);
      src_bytes.push_back(8'h5A);
      drain();

      // oversized width acts as 64, carrier code three acts as a word
      set_layout(2047, 2048, 127, 2'd3, 127, 0);
      repeat (4) src_bytes.push_back(8'hFF);
      repeat (3) src_bytes.push_back(8'h00);
      src_bytes.push_back(8'h80);
      drain();

      // 33-bit elements leave a partial fill behind
      set_layout(2047, 2048, 33, CARRIER_WORD, 64, 0);
      queue_random(5);
      drain();

      // width zero acts as one, and the partial fill drains at once
      set_layout(2047, 5, 0, CARRIER_HALF, 1, 0);
      queue_random(2);
      drain();

      // zero columns: bytes drop
      csr_write(CSR_COLUMN_COUNT, 0);
      queue_random(2);
      drain();

      for (chunk = 0; chunk < 10; chunk++) begin
         if (chunk == 3) begin
            send_idle_pct = 48;
            rsp_stall_pct = 18;
         end else if (chunk == 7) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         case ($urandom_range(0, 7))
            0:       bits = 0;
            1:       bits = 127;
            2:       bits = 64;
            3:       bits = $urandom_range(33, 63);
            default: bits = $urandom_range(1, 32);
         endcase
         case ($urandom_range(0, 3))
            0:       cols = 1;
            1:       cols = 2048;
            default: cols = $urandom_range(2, 40);
         endcase
         tcols = $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 64);
         rows = 2047;
         if (chunk == 9) begin
            // close the plane within a few elements, then the rest drops
            rows = cur_row + 1;
            cols = cur_col + $urandom_range(1, 4);
            bits = $urandom_range(1, 8);
         end
         set_layout(rows, cols, bits, 2'($urandom_range(0, 3)), tcols,
                    $urandom_range(0, 7));
         queue_random(15);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
